// ===== hw/rtl/pwkes_pkg.sv =====
package pwkes_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_FX,
      ST_FX_W,
      ST_FY,
      ST_FY_W,
      ST_SC,
      ST_SC_W,
      ST_WB
   } state_type;

   typedef struct packed {
      logic start;
      logic scale_mode;
   } mul_ctl_type;

   localparam logic [1:0] CSR_GRID_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_ENERGY_SCALE = 2'd2;

   localparam int SIZE_LIMIT = 1022;

   localparam logic [18:0] PHASE_MIN = 19'd2;
   localparam logic [18:0] PHASE_MAX = 19'd131070;
   localparam logic [18:0] PHASE_ONE = 19'd131072;

   // weight of one face: one minus the clamped doubled mean phase, Q0.17
   function automatic logic [16:0] face_weight(input logic [17:0] sa, input logic [17:0] sb);
      logic [18:0] p;
      logic [18:0] w;
      p = {1'b0, sa} + {1'b0, sb};
      if (p < PHASE_MIN) begin
         p = PHASE_MIN;
      end
      if (p > PHASE_MAX) begin
         p = PHASE_MAX;
      end
      w = PHASE_ONE - p;
      return w[16:0];
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/pwkes_mulsh.sv =====
module pwkes_mulsh (
   input  logic                   clock,
   input  logic                   reset,
   input  pwkes_pkg::mul_ctl_type ctl,
   input  logic [63:0]            a,
   input  logic [31:0]            b,
   output logic [63:0]            result,
   output logic                   done
);

   logic [3:0]  v_ff;
   logic [3:0]  v_in;
   logic        done_ff;
   logic        neg_ff;
   logic        mode_ff;
   logic [63:0] mag_ff;
   logic [31:0] b_ff;
   logic [63:0] p0_ff;
   logic [63:0] p1_ff;
   logic [95:0] sum_ff;
   logic [63:0] res_ff;

   logic [95:0] sh;
   logic [63:0] lim;
   logic [63:0] mag_r;
   logic [63:0] res_in;

   assign v_in = {v_ff[2:0], ctl.start};

   always_comb begin
      sh    = mode_ff ? (sum_ff >> 16) : (sum_ff >> 18);
      lim   = neg_ff ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      mag_r = ((sh[95:64] != 32'b0) || (sh[63:0] > lim)) ? lim : sh[63:0];
      res_in = neg_ff ? (64'b0 - mag_r) : mag_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         done_ff <= 1'b0;
      end else begin
         v_ff    <= v_in;
         done_ff <= v_ff[3];
      end
   end

   // magnitude times factor in two 32-bit halves, then shift, clip and restore sign
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         neg_ff  <= a[63];
         mag_ff  <= a[63] ? (64'b0 - a) : a;
         b_ff    <= b;
         mode_ff <= ctl.scale_mode;
      end
      if (v_ff[0]) begin
         p0_ff <= {32'b0, mag_ff[31:0]} * {32'b0, b_ff};
      end
      if (v_ff[1]) begin
         p1_ff <= {32'b0, mag_ff[63:32]} * {32'b0, b_ff};
      end
      if (v_ff[2]) begin
         sum_ff <= {p1_ff, 32'b0} + {32'b0, p0_ff};
      end
      if (v_ff[3]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

// ===== hw/rtl/phase_weighted_kinetic_energy_sum_top.sv =====
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_stall  face velocities and phases of one padded cell
// rsp      out        rsp_valid/rsp_stall  saturated frame energy total
// csr      in         csr_valid/csr_ready  register index and write data
//
// Each cell squares its velocities on one 32x32 multiplier, then runs up to three products
// (x face, y face, scaling) through one shared unit, and ends with a write-back to the
// line memories.
// Reset is synchronous; line memories are not cleared and hold nothing a frame reads
// before writing it. A stalled total holds in the output register; only the frame's
// last cell waits for it to drain.
module phase_weighted_kinetic_energy_sum_top #(
   parameter int MAX_ROW_LENGTH = 1024,
   parameter int MAX_ROWS       = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vel_x_before,
   input  logic signed [31:0] req_vel_x_after,
   input  logic signed [31:0] req_vel_y_before,
   input  logic signed [31:0] req_vel_y_after,
   input  logic [16:0]        req_phase_first,
   input  logic [16:0]        req_phase_second,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_energy_total,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int CW   = $clog2(MAX_ROW_LENGTH);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int WLIM = (MAX_ROW_LENGTH - 2 < pwkes_pkg::SIZE_LIMIT) ?
                         MAX_ROW_LENGTH - 2 : pwkes_pkg::SIZE_LIMIT;
   localparam int HLIM = (MAX_ROWS - 2 < pwkes_pkg::SIZE_LIMIT) ?
                         MAX_ROWS - 2 : pwkes_pkg::SIZE_LIMIT;

   // configuration
   logic [9:0]  grid_width_ff;
   logic [9:0]  grid_height_ff;
   logic [31:0] energy_scale_ff;

   // current cell
   logic signed [31:0] vxb_ff, vxa_ff, vyb_ff, vya_ff;
   logic [17:0]        s_ff;

   pwkes_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [2:0]         sq_step_ff;
   logic signed [31:0] sq_op;
   logic signed [63:0] sq_ff, sq_in;
   logic [63:0]        dx_ff, dy_ff;
   logic [63:0]        prev_dx_ff;
   logic [17:0]        prev_s_ff;
   logic [63:0]        pend_ff, pend_in;
   logic [63:0]        t_ff, t2_ff;
   logic [63:0]        total_ff;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_total_ff;

   // line memories: previous row's phase sum and y change, two rows of partial cell sums
   logic [81:0]        yp_mem [0:MAX_ROW_LENGTH-1];
   logic [63:0]        x_mem  [0:(2**(CW+1))-1];
   logic [81:0]        yp_rd_ff;
   logic [63:0]        x_rd_ff;

   logic [CW-1:0]      w_eff;
   logic [RW-1:0]      h_eff;
   logic               acc, col_zero, row_ge1, scored, row_end, frame_end, wb_go;

   pwkes_pkg::mul_ctl_type mul_ctl;
   logic [63:0]        mul_a;
   logic [31:0]        mul_b;
   logic [63:0]        mul_res;
   logic               mul_done;

   assign csr_ready = (state_ff == pwkes_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= 10'd64;
         grid_height_ff  <= 10'd64;
         energy_scale_ff <= 32'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pwkes_pkg::CSR_GRID_WIDTH:   grid_width_ff   <= csr_wdata[9:0];
            pwkes_pkg::CSR_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[9:0];
            pwkes_pkg::CSR_ENERGY_SCALE: energy_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(grid_width_ff) > WLIM) begin
         w_eff = CW'(WLIM);
      end else begin
         w_eff = CW'(grid_width_ff);
      end
      if (int'(grid_height_ff) > HLIM) begin
         h_eff = RW'(HLIM);
      end else begin
         h_eff = RW'(grid_height_ff);
      end
   end

   assign req_stall = (state_ff != pwkes_pkg::ST_IDLE);
   assign acc       = req_valid && !req_stall;
   assign col_zero  = (col_ff == '0);
   assign row_ge1   = (row_ff != '0);
   assign scored    = (row_ff >= RW'(2)) && !col_zero && (col_ff <= w_eff);
   assign row_end   = (col_ff >= w_eff + CW'(1));
   assign frame_end = row_end && (row_ff >= h_eff + RW'(1));
   assign wb_go     = (state_ff == pwkes_pkg::ST_WB) && !(frame_end && rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pwkes_pkg::ST_IDLE: if (acc) state_in = pwkes_pkg::ST_SQ;
         pwkes_pkg::ST_SQ:   if (sq_step_ff == 3'd4) state_in = pwkes_pkg::ST_FX;
         pwkes_pkg::ST_FX:   state_in = col_zero ? pwkes_pkg::ST_FY : pwkes_pkg::ST_FX_W;
         pwkes_pkg::ST_FX_W: if (mul_done) state_in = pwkes_pkg::ST_FY;
         pwkes_pkg::ST_FY:   state_in = row_ge1 ? pwkes_pkg::ST_FY_W : pwkes_pkg::ST_SC;
         pwkes_pkg::ST_FY_W: if (mul_done) state_in = pwkes_pkg::ST_SC;
         pwkes_pkg::ST_SC:   state_in = scored ? pwkes_pkg::ST_SC_W : pwkes_pkg::ST_WB;
         pwkes_pkg::ST_SC_W: if (mul_done) state_in = pwkes_pkg::ST_WB;
         pwkes_pkg::ST_WB:   if (wb_go) state_in = pwkes_pkg::ST_IDLE;
         default:            state_in = pwkes_pkg::ST_IDLE;
      endcase
   end

   // multiplier unit operands
   always_comb begin
      mul_ctl.start      = 1'b0;
      mul_ctl.scale_mode = 1'b0;
      mul_a              = prev_dx_ff;
      mul_b              = {15'b0, pwkes_pkg::face_weight(prev_s_ff, s_ff)};
      case (state_ff)
         pwkes_pkg::ST_FX: begin
            mul_ctl.start = !col_zero;
         end
         pwkes_pkg::ST_FY: begin
            mul_ctl.start = row_ge1;
            mul_a         = yp_rd_ff[63:0];
            mul_b         = {15'b0, pwkes_pkg::face_weight(yp_rd_ff[81:64], s_ff)};
         end
         pwkes_pkg::ST_SC: begin
            mul_ctl.start      = scored;
            mul_ctl.scale_mode = 1'b1;
            mul_a              = x_rd_ff + t2_ff;
            mul_b              = energy_scale_ff;
         end
         default: ;
      endcase
   end

   pwkes_mulsh u_mulsh (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .a      (mul_a),
      .b      (mul_b),
      .result (mul_res),
      .done   (mul_done)
   );

   always_comb begin
      case (sq_step_ff)
         3'd0:    sq_op = vxa_ff;
         3'd1:    sq_op = vxb_ff;
         3'd2:    sq_op = vya_ff;
         default: sq_op = vyb_ff;
      endcase
      sq_in   = sq_op * sq_op;
      pend_in = t_ff + t2_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwkes_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         sq_step_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         prev_dx_ff   <= '0;
         prev_s_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (wb_go && frame_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == pwkes_pkg::ST_SQ) begin
            sq_step_ff <= (sq_step_ff == 3'd4) ? 3'd0 : sq_step_ff + 3'd1;
         end
         if ((state_ff == pwkes_pkg::ST_SC_W) && mul_done) begin
            total_ff <= pwkes_pkg::sat_add(total_ff, mul_res);
         end
         if (wb_go) begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            prev_dx_ff <= dx_ff;
            prev_s_ff  <= s_ff;
            if (frame_end) begin
               total_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         vxb_ff <= req_vel_x_before;
         vxa_ff <= req_vel_x_after;
         vyb_ff <= req_vel_y_before;
         vya_ff <= req_vel_y_after;
         s_ff   <= {1'b0, req_phase_first} + {1'b0, req_phase_second};
      end
      if (state_ff == pwkes_pkg::ST_SQ) begin
         if (sq_step_ff != 3'd4) begin
            sq_ff <= sq_in;
         end
         case (sq_step_ff)
            3'd1:    dx_ff <= sq_ff;
            3'd2:    dx_ff <= dx_ff - sq_ff;
            3'd3:    dy_ff <= sq_ff;
            3'd4:    dy_ff <= dy_ff - sq_ff;
            default: ;
         endcase
      end
      if (state_ff == pwkes_pkg::ST_FX) begin
         t_ff <= '0;
      end else if ((state_ff == pwkes_pkg::ST_FX_W) && mul_done) begin
         t_ff <= mul_res;
      end
      if (state_ff == pwkes_pkg::ST_FY) begin
         t2_ff <= '0;
      end else if ((state_ff == pwkes_pkg::ST_FY_W) && mul_done) begin
         t2_ff <= mul_res;
      end
      if (wb_go) begin
         pend_ff <= pend_in;
         if (frame_end) begin
            rsp_total_ff <= total_ff;
         end
      end
   end

   // read at accept, write back once the cell is done
   always_ff @(posedge clock) begin
      if (acc) begin
         yp_rd_ff <= yp_mem[col_ff];
         x_rd_ff  <= x_mem[{~row_ff[0], col_ff}];
      end
      if (wb_go) begin
         yp_mem[col_ff] <= {s_ff, dy_ff};
      end
      // close the left neighbor's partial sum with the shared x face
      if (wb_go && !col_zero) begin
         x_mem[{row_ff[0], col_ff - CW'(1)}] <= pend_ff + t_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_energy_total = rsp_total_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic signed [31:0] vxb;
      logic signed [31:0] vxa;
      logic signed [31:0] vyb;
      logic signed [31:0] vya;
      logic [16:0]        pa;
      logic [16:0]        pb;
   } cell_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_vel_x_before = '0;
   logic signed [31:0] req_vel_x_after = '0;
   logic signed [31:0] req_vel_y_before = '0;
   logic signed [31:0] req_vel_y_after = '0;
   logic [16:0]        req_phase_first = '0;
   logic [16:0]        req_phase_second = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [63:0] rsp_energy_total;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   phase_weighted_kinetic_energy_sum_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   int unsigned     cfg_width = 64;
   int unsigned     cfg_height = 64;
   logic [31:0]     cfg_scale = 32'd65536;
   int unsigned     col_pos = 0;
   int unsigned     row_pos = 0;
   logic [17:0]     phase_row [1024];
   longint          dy_row [1024];
   longint          xsum [2][1024];
   longint          left_dx = 0;
   logic [17:0]     left_phase = '0;
   longint          frame_total = 0;
   longint          expected_totals [$];

   int              mismatches = 0;
   int              cells_sent = 0;
   int              totals_seen = 0;
   int              burst_left = 0;
   int              hold_pending = 0;

   // a * b / 2^k, truncated toward zero, clipped to 64 bits
   function automatic longint scale_trunc(longint a, logic [31:0] b, int k);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] r;
      neg = a < 0;
      mag = {64'd0, neg ? 64'd0 - 64'(a) : 64'(a)};
      r = (mag * {96'd0, b}) >> k;
      if (neg && r > 128'h8000_0000_0000_0000) r = 128'h8000_0000_0000_0000;
      if (!neg && r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
      return neg ? longint'(64'd0 - r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic longint clip_add(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
      return longint'(s[63:0]);
   endfunction

   function automatic longint face_energy(longint d, logic [17:0] sa, logic [17:0] sb);
      int unsigned p;
      p = sa + sb;
      if (p < 2) p = 2;
      if (p > 131070) p = 131070;
      return scale_trunc(d, 32'(131072 - p), 18);
   endfunction

   function automatic int unsigned size_eff(int unsigned v);
      return (v > pwkes_pkg::SIZE_LIMIT) ? pwkes_pkg::SIZE_LIMIT : v;
   endfunction

   task automatic predict_cell(cell_type c);
      int unsigned w;
      int unsigned h;
      int unsigned cur;
      int unsigned prv;
      longint      dx;
      longint      dy;
      longint      t;
      longint      cellsum;
      logic [17:0] s;
      w = size_eff(cfg_width);
      h = size_eff(cfg_height);
      cur = row_pos & 1;
      prv = cur ^ 1;
      dx = longint'(c.vxa) * longint'(c.vxa) - longint'(c.vxb) * longint'(c.vxb);
      dy = longint'(c.vya) * longint'(c.vya) - longint'(c.vyb) * longint'(c.vyb);
      s = 18'(c.pa) + 18'(c.pb);
      if (col_pos == 0) begin
         xsum[cur][0] = 0;
      end else begin
         t = face_energy(left_dx, left_phase, s);
         xsum[cur][col_pos - 1] += t;
         xsum[cur][col_pos] = t;
      end
      if (row_pos >= 1) begin
         t = face_energy(dy_row[col_pos], phase_row[col_pos], s);
         cellsum = xsum[prv][col_pos] + t;
         xsum[cur][col_pos] += t;
         if (row_pos >= 2 && col_pos >= 1 && col_pos <= w)
            frame_total = clip_add(frame_total, scale_trunc(cellsum, cfg_scale, 16));
      end
      dy_row[col_pos] = dy;
      phase_row[col_pos] = s;
      left_dx = dx;
      left_phase = s;
      if (col_pos >= w + 1) begin
         col_pos = 0;
         if (row_pos >= h + 1) begin
            expected_totals.push_back(frame_total);
            frame_total = 0;
            row_pos = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endtask

   // drive one beat; valid stays high across a burst
   task automatic send_cell(cell_type c);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_vel_x_before <= c.vxb;
      req_vel_x_after <= c.vxa;
      req_vel_y_before <= c.vyb;
      req_vel_y_after <= c.vya;
      req_phase_first <= c.pa;
      req_phase_second <= c.pb;
      do @(posedge clock); while (req_stall);
      predict_cell(c);
      cells_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // leave valid high; the caller drops it after the last write
   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pwkes_pkg::CSR_GRID_WIDTH:   cfg_width = data[9:0];
         pwkes_pkg::CSR_GRID_HEIGHT:  cfg_height = data[9:0];
         pwkes_pkg::CSR_ENERGY_SCALE: cfg_scale = data;
         default: ;
      endcase
   endtask

   task automatic set_frame(int unsigned w, int unsigned h, logic [31:0] scale);
      write_reg(pwkes_pkg::CSR_GRID_WIDTH, w);
      write_reg(pwkes_pkg::CSR_GRID_HEIGHT, h);
      write_reg(pwkes_pkg::CSR_ENERGY_SCALE, scale);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] rand_vel();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2, 3: return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] rand_phase();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom);
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic cell_type rand_cell();
      cell_type c;
      c.vxb = rand_vel();
      c.vxa = rand_vel();
      c.vyb = rand_vel();
      c.vya = rand_vel();
      c.pa = rand_phase();
      c.pb = rand_phase();
      return c;
   endfunction

   function automatic logic [31:0] rand_scale();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd65536;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_frame();
      int unsigned n;
      n = (size_eff(cfg_width) + 2) * (size_eff(cfg_height) + 2);
      repeat (n) send_cell(rand_cell());
   endtask

   // extremes of velocities and phases, empty frame, saturating scale
   task automatic test_directed;
      cell_type c;
      logic signed [31:0] v [4];
      logic [16:0] p [4];
      v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1};
      p = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1};
      set_frame(1, 1, 32'hFFFF_FFFF);
      for (int i = 0; i < 9; i++) begin
         c.vxb = v[i % 4];
         c.vxa = v[(i + 1) % 4];
         c.vyb = v[(i + 2) % 4];
         c.vya = v[(i + 3) % 4];
         c.pa = p[i % 4];
         c.pb = p[(i + i / 4) % 4];
         send_cell(c);
      end
      drain();
      set_frame(0, 0, 32'd65536);
      repeat (4) send_cell(rand_cell());
      drain();
      set_frame(2, 1, 32'd1);
      for (int i = 0; i < 12; i++) begin
         c.vxb = 32'sh8000_0000;
         c.vxa = (i % 2) ? 32'sh7FFF_FFFF : 32'sd0;
         c.vyb = 32'sd0;
         c.vya = 32'sh8000_0000;
         c.pa = 17'd0;
         c.pb = (i % 3 == 0) ? 17'h1FFFF : 17'd0;
         send_cell(c);
      end
      drain();
   endtask

   // one wide and one tall frame
   task automatic test_large_sizes;
      set_frame(30, 1, rand_scale());
      send_frame();
      drain();
      set_frame(1, 30, rand_scale());
      send_frame();
      drain();
   endtask

   task automatic test_random_frames;
      int start;
      int frames;
      start = cells_sent;
      frames = 0;
      while (cells_sent - start < 160 || frames < 10) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            set_frame($urandom_range(0, 5), $urandom_range(0, 5), rand_scale());
         end
         send_frame();
         frames++;
      end
      drain();
   endtask

   // hold the result channel off while tiny frames keep coming
   task automatic test_backpressure;
      set_frame(0, 0, rand_scale());
      hold_pending = 1;
      repeat (12) send_frame();
      drain();
   endtask

   // receiver stall pattern
   int stall_mode = 0;
   int hold_left = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_pending != 0) begin
            hold_pending = 0;
            hold_left = 500;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         totals_seen++;
         if (expected_totals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected total %0d", rsp_energy_total);
         end else begin
            longint want;
            want = expected_totals.pop_front();
            if (rsp_energy_total !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("total mismatch: expected %0d actual %0d", want, rsp_energy_total);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_frames();
      test_backpressure();
      test_large_sizes();
      drain();
      if (expected_totals.size() != 0) mismatches++;
      $display("%0d cells sent over %0d frame totals, sizes 0 to 30, scale 0 to max,",
               cells_sent, totals_seen);
      $display("with random gaps, stalls and one long result hold-off; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
